// ===== design/bsc_pkg.sv =====
// Shared types and constants for the barometric sensor compensation block.
package bsc_pkg;

  // One raw sample word on the input channel.
  typedef struct packed {
    logic        operation;
    logic [15:0] raw_sample;
  } in_word_t;

  // One compensated result word on the output channel.
  typedef struct packed {
    logic               kind;
    logic signed [31:0] value;
    logic               div_error;
  } out_word_t;

  // Sample kinds.
  localparam logic OP_TEMPERATURE = 1'b0;
  localparam logic OP_PRESSURE    = 1'b1;

  // Calibration register slots (byte address is 8 times the slot).
  typedef enum logic [1:0] {
    REG_CAL_AC123 = 2'd0,
    REG_CAL_AC456 = 2'd1,
    REG_CAL_B12   = 2'd2,
    REG_CAL_MCMD  = 2'd3
  } cfg_reg_t;

  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 64;

  // Constants of the compensation formulas.
  localparam logic signed [31:0] K_B6_OFFSET  = 32'sd4000;
  localparam logic signed [31:0] K_B4_OFFSET  = 32'sd32768;
  localparam logic [31:0]        K_B7_SCALE   = 32'd50000;
  localparam logic signed [31:0] K_P_SQUARE   = 32'sd3038;
  localparam logic signed [31:0] K_P_LINEAR   = -32'sd7357;
  localparam logic signed [31:0] K_P_OFFSET   = 32'sd3791;
  localparam logic signed [31:0] K_T_ROUND    = 32'sd8;
  localparam logic signed [31:0] K_B3_ROUND   = 32'sd2;

  // Sequencer states, one-hot.
  typedef enum logic [19:0] {
    S_IDLE     = 20'h00001,
    S_T_MUL    = 20'h00002,
    S_T_DEN    = 20'h00004,
    S_T_DIV    = 20'h00008,
    S_T_FIN    = 20'h00010,
    S_P_B6     = 20'h00020,
    S_P_SQ     = 20'h00040,
    S_P_X1     = 20'h00080,
    S_P_X2     = 20'h00100,
    S_P_B3     = 20'h00200,
    S_P_X1B    = 20'h00400,
    S_P_X3     = 20'h00800,
    S_P_B4     = 20'h01000,
    S_P_B7     = 20'h02000,
    S_P_DIVLD  = 20'h04000,
    S_P_DIV    = 20'h08000,
    S_P_Q      = 20'h10000,
    S_P_K1     = 20'h20000,
    S_P_K2     = 20'h40000,
    S_P_FIN    = 20'h80000
  } seq_state_t;

endpackage

// ===== design/barometric_sensor_compensation.sv =====
// Top level: barometric sensor compensation with a shared multiplier and divider.
//
//   Channel   Ports                               Direction  Carries
//   --------  ----------------------------------  ---------  -----------------------------
//   input     in_valid, in_stall, in_data         in         one raw sample word
//   output    out_valid, out_stall, out_data      out        one compensated result word
//   config    psel, penable, pwrite, paddr,       in/out     four calibration registers
//             pwdata, prdata, pready
//
// A zero divisor ends a word early. Most of the time a word spends in the sequencer goes to
// the radix-2 divider, and the single 32x32 multiplier serializes the remaining terms.
// Reset is synchronous and active low; it clears the calibration registers and the stored
// B5 term. A result waits in the output register while the next word is already accepted.
module barometric_sensor_compensation (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  bsc_pkg::in_word_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output bsc_pkg::out_word_t                out_data,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [bsc_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [bsc_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [bsc_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                              pready
);
  import bsc_pkg::*;

  // Calibration registers.
  logic [47:0] cal_ac123_r, cal_ac123_nxt;
  logic [47:0] cal_ac456_r, cal_ac456_nxt;
  logic [31:0] cal_b12_r,   cal_b12_nxt;
  logic [31:0] cal_mcmd_r,  cal_mcmd_nxt;

  // Sequencer and working registers.
  seq_state_t         state_r, state_nxt;
  logic               op_r, op_nxt;
  logic [15:0]        raw_r, raw_nxt;
  logic [31:0]        prod_r, prod_nxt;
  logic signed [31:0] acc_r, acc_nxt;
  logic signed [31:0] b6_r, b6_nxt;
  logic signed [31:0] sq_r, sq_nxt;
  logic signed [31:0] b3_r, b3_nxt;
  logic [31:0]        b4_r, b4_nxt;
  logic signed [31:0] p_r, p_nxt;
  logic signed [31:0] temp_term_r, temp_term_nxt;

  // Divider registers.
  logic [31:0] rem_r, rem_nxt;
  logic [31:0] quo_r, quo_nxt;
  logic [31:0] dvs_r, dvs_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        qneg_r, qneg_nxt;
  logic        dbl_r, dbl_nxt;

  // Output register.
  logic      out_valid_r, out_valid_nxt;
  out_word_t out_data_r, out_data_nxt;

  // Calibration fields, extended to 32 bits.
  logic signed [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;

  assign ac1 = {{16{cal_ac123_r[47]}}, cal_ac123_r[47:32]};
  assign ac2 = {{16{cal_ac123_r[31]}}, cal_ac123_r[31:16]};
  assign ac3 = {{16{cal_ac123_r[15]}}, cal_ac123_r[15:0]};
  assign ac4 = {16'b0, cal_ac456_r[47:32]};
  assign ac5 = {16'b0, cal_ac456_r[31:16]};
  assign ac6 = {16'b0, cal_ac456_r[15:0]};
  assign b1  = {{16{cal_b12_r[31]}}, cal_b12_r[31:16]};
  assign b2  = {{16{cal_b12_r[15]}}, cal_b12_r[15:0]};
  assign mc  = {{16{cal_mcmd_r[31]}}, cal_mcmd_r[31:16]};
  assign md  = {{16{cal_mcmd_r[15]}}, cal_mcmd_r[15:0]};

  // The configuration port is always ready; reads come straight from the registers.
  logic     cfg_we;
  cfg_reg_t cfg_sel;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready;
  assign cfg_sel = cfg_reg_t'(paddr[CFG_ADDR_W-1:3]);

  always_comb begin
    unique case (cfg_sel)
      REG_CAL_AC123: prdata = {16'b0, cal_ac123_r};
      REG_CAL_AC456: prdata = {16'b0, cal_ac456_r};
      REG_CAL_B12:   prdata = {32'b0, cal_b12_r};
      REG_CAL_MCMD:  prdata = {32'b0, cal_mcmd_r};
      default:       prdata = '0;
    endcase
  end

  always_comb begin
    cal_ac123_nxt = cal_ac123_r;
    cal_ac456_nxt = cal_ac456_r;
    cal_b12_nxt   = cal_b12_r;
    cal_mcmd_nxt  = cal_mcmd_r;
    if (cfg_we) begin
      unique case (cfg_sel)
        REG_CAL_AC123: cal_ac123_nxt = pwdata[47:0];
        REG_CAL_AC456: cal_ac456_nxt = pwdata[47:0];
        REG_CAL_B12:   cal_b12_nxt   = pwdata[31:0];
        REG_CAL_MCMD:  cal_mcmd_nxt  = pwdata[31:0];
        default: ;
      endcase
    end
  end

  // Handshakes. The sequencer takes a new word only from its idle state, while the output
  // register may still hold the previous result.
  logic in_accept, out_take, out_free;

  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_take  = out_valid_r && !out_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Shared multiplier: wrapping 32x32 product, registered in prod_r.
  logic [31:0] mul_a, mul_b;
  logic [31:0] mul_lo;
  logic        mul_en;

  assign mul_lo = mul_a * mul_b;

  // Shared radix-2 restoring divider step.
  logic [32:0] rem_sh;
  logic [33:0] div_diff;
  logic [31:0] div_rem_step, div_quo_step;
  logic        div_last;

  assign rem_sh   = {rem_r, quo_r[31]};
  assign div_diff = {1'b0, rem_sh} - {2'b0, dvs_r};
  assign div_last = (cnt_r == 5'd31);

  always_comb begin
    if (!div_diff[33]) begin
      div_rem_step = div_diff[31:0];
      div_quo_step = {quo_r[30:0], 1'b1};
    end else begin
      div_rem_step = rem_sh[31:0];
      div_quo_step = {quo_r[30:0], 1'b0};
    end
  end

  // Intermediate terms of the individual steps.
  logic signed [31:0] prod_s, t_x1, t_den, t_dvd, t_x2, t_b5, x3, p_val, p_sh, b7_diff;
  logic [31:0]        b7;

  assign prod_s  = $signed(prod_r);
  assign t_x1    = prod_s >>> 15;
  assign t_den   = t_x1 + md;
  assign t_dvd   = {mc[26:0], 5'b0} <<< 6;
  assign t_x2    = qneg_r ? -$signed(quo_r) : $signed(quo_r);
  assign t_b5    = acc_r + t_x2;
  assign x3      = acc_r + (prod_s >>> 11);
  assign b7      = prod_r;
  assign p_val   = dbl_r ? $signed({quo_r[30:0], 1'b0}) : $signed(quo_r);
  assign p_sh    = p_val >>> 8;
  assign b7_diff = $signed({16'b0, raw_r}) - b3_r;

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    raw_nxt       = raw_r;
    acc_nxt       = acc_r;
    b6_nxt        = b6_r;
    sq_nxt        = sq_r;
    b3_nxt        = b3_r;
    b4_nxt        = b4_r;
    p_nxt         = p_r;
    temp_term_nxt = temp_term_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    dvs_nxt       = dvs_r;
    cnt_nxt       = cnt_r;
    qneg_nxt      = qneg_r;
    dbl_nxt       = dbl_r;
    mul_en        = 1'b0;
    mul_a         = '0;
    mul_b         = '0;
    out_valid_nxt = out_take ? 1'b0 : out_valid_r;
    out_data_nxt  = out_data_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          op_nxt    = in_data.operation;
          raw_nxt   = in_data.raw_sample;
          state_nxt = (in_data.operation == OP_PRESSURE) ? S_P_B6 : S_T_MUL;
        end
      end

      // Temperature: X1 = ((UT - AC6) * AC5) >> 15, X2 = MC * 2048 / (X1 + MD).
      S_T_MUL: begin
        mul_en    = 1'b1;
        mul_a     = $signed({16'b0, raw_r}) - ac6;
        mul_b     = ac5;
        state_nxt = S_T_DEN;
      end
      S_T_DEN: begin
        acc_nxt = t_x1;
        if (t_den == 32'sd0) begin
          // A zero divisor gives an error result and leaves B5 untouched.
          if (out_free) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = '{kind: OP_TEMPERATURE, value: '0, div_error: 1'b1};
            state_nxt     = S_IDLE;
          end
        end else begin
          rem_nxt   = '0;
          cnt_nxt   = '0;
          quo_nxt   = t_dvd[31] ? -t_dvd : t_dvd;
          dvs_nxt   = t_den[31] ? -t_den : t_den;
          qneg_nxt  = t_dvd[31] ^ t_den[31];
          state_nxt = S_T_DIV;
        end
      end
      S_T_DIV: begin
        rem_nxt = div_rem_step;
        quo_nxt = div_quo_step;
        cnt_nxt = cnt_r + 5'd1;
        if (div_last) begin
          state_nxt = S_T_FIN;
        end
      end
      S_T_FIN: begin
        if (out_free) begin
          temp_term_nxt = t_b5;
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{kind: OP_TEMPERATURE, value: (t_b5 + K_T_ROUND) >>> 4,
                            div_error: 1'b0};
          state_nxt     = S_IDLE;
        end
      end

      // Pressure: the B3 and B4 terms, then B7 / B4, then the final polynomial.
      S_P_B6: begin
        b6_nxt    = temp_term_r - K_B6_OFFSET;
        state_nxt = S_P_SQ;
      end
      S_P_SQ: begin
        mul_en    = 1'b1;
        mul_a     = b6_r;
        mul_b     = b6_r;
        state_nxt = S_P_X1;
      end
      S_P_X1: begin
        sq_nxt    = prod_s >>> 12;
        mul_en    = 1'b1;
        mul_a     = b2;
        mul_b     = prod_s >>> 12;
        state_nxt = S_P_X2;
      end
      S_P_X2: begin
        acc_nxt   = prod_s >>> 11;
        mul_en    = 1'b1;
        mul_a     = ac2;
        mul_b     = b6_r;
        state_nxt = S_P_B3;
      end
      S_P_B3: begin
        b3_nxt    = ((ac1 <<< 2) + x3 + K_B3_ROUND) >>> 2;
        mul_en    = 1'b1;
        mul_a     = ac3;
        mul_b     = b6_r;
        state_nxt = S_P_X1B;
      end
      S_P_X1B: begin
        acc_nxt   = prod_s >>> 13;
        mul_en    = 1'b1;
        mul_a     = b1;
        mul_b     = sq_r;
        state_nxt = S_P_X3;
      end
      S_P_X3: begin
        acc_nxt   = ((acc_r + (prod_s >>> 16) + K_B3_ROUND) >>> 2) + K_B4_OFFSET;
        state_nxt = S_P_B4;
      end
      S_P_B4: begin
        mul_en    = 1'b1;
        mul_a     = ac4;
        mul_b     = acc_r;
        state_nxt = S_P_B7;
      end
      S_P_B7: begin
        b4_nxt    = prod_r >> 15;
        mul_en    = 1'b1;
        mul_a     = b7_diff;
        mul_b     = K_B7_SCALE;
        state_nxt = S_P_DIVLD;
      end
      S_P_DIVLD: begin
        if (b4_r == 32'd0) begin
          if (out_free) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = '{kind: OP_PRESSURE, value: '0, div_error: 1'b1};
            state_nxt     = S_IDLE;
          end
        end else begin
          // Doubling before the divide would overflow when B7 has its top bit set,
          // so the quotient is doubled afterwards in that case.
          rem_nxt   = '0;
          cnt_nxt   = '0;
          quo_nxt   = b7[31] ? b7 : {b7[30:0], 1'b0};
          dvs_nxt   = b4_r;
          qneg_nxt  = 1'b0;
          dbl_nxt   = b7[31];
          state_nxt = S_P_DIV;
        end
      end
      S_P_DIV: begin
        rem_nxt = div_rem_step;
        quo_nxt = div_quo_step;
        cnt_nxt = cnt_r + 5'd1;
        if (div_last) begin
          state_nxt = S_P_Q;
        end
      end
      S_P_Q: begin
        p_nxt     = p_val;
        mul_en    = 1'b1;
        mul_a     = p_sh;
        mul_b     = p_sh;
        state_nxt = S_P_K1;
      end
      S_P_K1: begin
        mul_en    = 1'b1;
        mul_a     = prod_r;
        mul_b     = K_P_SQUARE;
        state_nxt = S_P_K2;
      end
      S_P_K2: begin
        acc_nxt   = prod_s >>> 16;
        mul_en    = 1'b1;
        mul_a     = K_P_LINEAR;
        mul_b     = p_r;
        state_nxt = S_P_FIN;
      end
      S_P_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{kind: OP_PRESSURE,
                            value: p_r + ((acc_r + (prod_s >>> 16) + K_P_OFFSET) >>> 4),
                            div_error: 1'b0};
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign prod_nxt = mul_en ? mul_lo : prod_r;

  // Control state and calibration, cleared by reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      temp_term_r <= '0;
      cal_ac123_r <= '0;
      cal_ac456_r <= '0;
      cal_b12_r   <= '0;
      cal_mcmd_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      temp_term_r <= temp_term_nxt;
      cal_ac123_r <= cal_ac123_nxt;
      cal_ac456_r <= cal_ac456_nxt;
      cal_b12_r   <= cal_b12_nxt;
      cal_mcmd_r  <= cal_mcmd_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    raw_r      <= raw_nxt;
    prod_r     <= prod_nxt;
    acc_r      <= acc_nxt;
    b6_r       <= b6_nxt;
    sq_r       <= sq_nxt;
    b3_r       <= b3_nxt;
    b4_r       <= b4_nxt;
    p_r        <= p_nxt;
    rem_r      <= rem_nxt;
    quo_r      <= quo_nxt;
    dvs_r      <= dvs_nxt;
    qneg_r     <= qneg_nxt;
    dbl_r      <= dbl_nxt;
    out_data_r <= out_data_nxt;
  end

  // An accepted word keeps the sequencer busy on the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> in_stall)
    else $error("sequencer ready again right after accepting a word");

  // The divider count only advances inside a divide.
  a_div_count_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != 5'd0) |-> (state_r == S_T_DIV || state_r == S_P_DIV))
    else $error("divider count running outside a divide");

  // A freshly presented result is of the kind of the word that produced it.
  a_kind_matches: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> (out_data_r.kind == op_r))
    else $error("result kind differs from the sample operation");

  // An error result always carries a zero value.
  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!out_data_r.div_error || out_data_r.value == 32'sd0))
    else $error("division error result with a nonzero value");

  // B5 changes only when a temperature result is written.
  a_b5_update: assert property (@(posedge clk) disable iff (!rst_n)
    (temp_term_r != $past(temp_term_r)) |-> $past(state_r == S_T_FIN))
    else $error("stored B5 term changed outside temperature completion");

endmodule

// ===== tb/tb_barometric_sensor_compensation.sv =====
// Self-checking testbench for the barometric sensor compensation block.
`timescale 1ns / 100ps

module tb_barometric_sensor_compensation;
  import bsc_pkg::*;

  // A word slower than this many cycles with work outstanding counts as a hang.
  // The slowest pressure word and the stall and gap bursts are all far shorter,
  // so this leaves a wide margin.
  localparam int STUCK_LIMIT = 2000;
  // Cycles to watch for stray results once everything expected has arrived.
  localparam int TAIL_CYCLES = 120;

  // Typical calibration set from the published example, used in the directed part.
  localparam logic [47:0] TYPICAL_AC123 = 48'h0198_FFB8_C7D1;  // 408, -72, -14383
  localparam logic [47:0] TYPICAL_AC456 = 48'h7FE5_7FF5_5A71;  // 32741, 32757, 23153
  localparam logic [31:0] TYPICAL_B12   = 32'h182E_0004;       // 6190, 4
  localparam logic [31:0] TYPICAL_MCMD  = 32'hDDF9_0B34;       // -8711, 2868

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_data;
  logic      psel = 1'b0;
  logic      penable = 1'b0;
  logic      pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic      pready;

  // Samples waiting to be offered, and compensated results waiting to come out.
  in_word_t  pending_samples[$];
  out_word_t expected_results[$];

  // Shadow copies of the calibration registers and of the stored B5 term.
  logic [63:0] cal_ac123 = '0;
  logic [63:0] cal_ac456 = '0;
  logic [63:0] cal_b12 = '0;
  logic [63:0] cal_mcmd = '0;
  int          b5_term = 0;

  int   error_count = 0;
  int   stuck_cycles = 0;
  int   gap_pct = 0;     // chance in percent that a free input slot starts an idle burst
  int   stall_pct = 0;   // chance in percent that the result side starts a stall burst
  int   gap_left = 0;
  int   stall_left = 0;
  logic in_taken = 1'b0; // the input word was accepted at the last rising edge

  barometric_sensor_compensation dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Works out the compensated result of one raw sample from the shadow calibration
  // and the stored B5 term. All signed terms wrap at 32 bits, shifts are arithmetic
  // and the divisions truncate toward zero; B4 and B7 are unsigned 32-bit terms.
  function automatic out_word_t compensate(in_word_t w);
    out_word_t   r;
    int          ac1, ac2, ac3, ac5, ac6, b1, b2, mc, md;
    int          x1, x2, x3, den, b3, b5, b6, sq, p;
    int unsigned ac4, b4, b7, q, up, ub;
    r.kind = w.operation;
    r.value = 0;
    r.div_error = 1'b0;
    if (w.operation == OP_TEMPERATURE) begin
      ac5 = int'(cal_ac456[31:16]);
      ac6 = int'(cal_ac456[15:0]);
      mc = int'($signed(cal_mcmd[31:16]));
      md = int'($signed(cal_mcmd[15:0]));
      x1 = ((int'(w.raw_sample) - ac6) * ac5) >>> 15;
      den = x1 + md;
      if (den == 0) begin
        // A zero divisor flags the error and leaves B5 as it was.
        r.div_error = 1'b1;
      end else begin
        x2 = int'((longint'(mc) * 2048) / longint'(den));
        b5 = x1 + x2;
        b5_term = b5;
        r.value = (b5 + K_T_ROUND) >>> 4;
      end
    end else begin
      ac1 = int'($signed(cal_ac123[47:32]));
      ac2 = int'($signed(cal_ac123[31:16]));
      ac3 = int'($signed(cal_ac123[15:0]));
      ac4 = 32'(cal_ac456[47:32]);
      b1 = int'($signed(cal_b12[31:16]));
      b2 = int'($signed(cal_b12[15:0]));
      b6 = b5_term - K_B6_OFFSET;
      sq = (b6 * b6) >>> 12;
      x1 = (b2 * sq) >>> 11;
      x2 = (ac2 * b6) >>> 11;
      b3 = ((ac1 * 4) + x1 + x2 + K_B3_ROUND) >>> 2;
      x1 = (ac3 * b6) >>> 13;
      x2 = (b1 * sq) >>> 16;
      x3 = (x1 + x2 + 2) >>> 2;
      ub = x3 + K_B4_OFFSET;
      b4 = (ac4 * ub) >> 15;
      up = 32'(w.raw_sample);
      ub = b3;
      b7 = (up - ub) * K_B7_SCALE;
      if (b4 == 0) begin
        r.div_error = 1'b1;
      end else begin
        // The order of doubling and dividing depends on whether B7 would overflow.
        q = (b7 < 32'h8000_0000) ? (b7 * 2) / b4 : (b7 / b4) * 2;
        p = q;
        x1 = p >>> 8;
        x1 = x1 * x1;
        x1 = (x1 * K_P_SQUARE) >>> 16;
        x2 = (K_P_LINEAR * p) >>> 16;
        p = p + ((x1 + x2 + K_P_OFFSET) >>> 4);
        r.value = p;
      end
    end
    return r;
  endfunction

  // Input side driver. A new word goes out only once the current one has been
  // taken, so a stalled word never changes. Idle bursts start only while words
  // are waiting, which spreads them over every phase of the block's sequence.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left--;
      end else if (pending_samples.size() == 0) begin
        in_valid <= 1'b0;
      end else if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
        in_valid <= 1'b0;
        gap_left = $urandom_range(18, 0);
      end else begin
        in_data <= pending_samples.pop_front();
        in_valid <= 1'b1;
      end
    end
  end

  // Result side stall, in bursts whose length is drawn at random.
  always @(negedge clk) begin
    if (!rst_n || stall_pct == 0) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if ($urandom_range(99) < stall_pct) begin
      out_stall <= 1'b1;
      stall_left = $urandom_range(18, 0);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Monitor for both channels. The result is checked before a word accepted at the
  // same edge adds its expectation, so the queue order never depends on the event order.
  always @(posedge clk) begin
    out_word_t want;
    in_taken <= rst_n && in_valid && !in_stall;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result: expected none, actual kind %0d value %0d err %0d",
                 $time, out_data.kind, out_data.value, out_data.div_error);
      end else begin
        want = expected_results.pop_front();
        if (out_data.kind !== want.kind || out_data.value !== want.value ||
            out_data.div_error !== want.div_error) begin
          error_count++;
          $display("%0t: result mismatch: expected kind %0d value %0d err %0d, %s%0d%s%0d%s%0d",
                   $time, want.kind, want.value, want.div_error,
                   "actual kind ", out_data.kind, " value ", out_data.value,
                   " err ", out_data.div_error);
        end
      end
    end
    if (rst_n && in_valid && !in_stall)
      expected_results.push_back(compensate(in_data));
  end

  // Watchdog: counts cycles with work outstanding but no word moving on either side.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
        (pending_samples.size() == 0 && !in_valid && expected_results.size() == 0)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
      if (stuck_cycles == STUCK_LIMIT) begin
        $display("%0t: no word moved for %0d cycles", $time, STUCK_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Writes one calibration register over the APB port, then reads it back.
  // Only called while the block is idle.
  task automatic cal_write(cfg_reg_t slot, logic [63:0] data);
    logic [63:0] stored;
    stored = data & ((slot == REG_CAL_AC123 || slot == REG_CAL_AC456) ?
                     64'h0000_FFFF_FFFF_FFFF : 64'h0000_0000_FFFF_FFFF);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {slot, 3'b000};
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (slot)
      REG_CAL_AC123: cal_ac123 = stored;
      REG_CAL_AC456: cal_ac456 = stored;
      REG_CAL_B12:   cal_b12 = stored;
      REG_CAL_MCMD:  cal_mcmd = stored;
    endcase
    // Back-to-back read of the same register.
    @(negedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== stored) begin
      error_count++;
      $display("%0t: register %s readback: expected %h, actual %h",
               $time, slot.name(), stored, prdata);
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic cal_write_all(logic [63:0] ac123, logic [63:0] ac456,
                               logic [63:0] b12, logic [63:0] mcmd);
    cal_write(REG_CAL_AC123, ac123);
    cal_write(REG_CAL_AC456, ac456);
    cal_write(REG_CAL_B12, b12);
    cal_write(REG_CAL_MCMD, mcmd);
  endtask

  task automatic send_sample(logic op, logic [15:0] raw);
    in_word_t w;
    w.operation = op;
    w.raw_sample = raw;
    pending_samples.push_back(w);
  endtask

  // Waits until every queued word has been taken and every result has arrived.
  task automatic drain();
    while (pending_samples.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
  endtask

  // Queues a run of random samples. The realistic form mostly sends a temperature
  // reading followed by a few pressure readings in the sensor's usual ranges,
  // with some fully random words mixed in; the other form is uniform noise.
  task automatic queue_samples(int count, bit realistic);
    int n;
    int reps;
    n = 0;
    while (n < count) begin
      if (!realistic || $urandom_range(9) == 0) begin
        send_sample(1'($urandom_range(1)), 16'($urandom_range(65535)));
        n++;
      end else begin
        send_sample(OP_TEMPERATURE, 16'($urandom_range(34000, 22000)));
        n++;
        reps = $urandom_range(4, 1);
        for (int i = 0; i < reps && n < count; i++) begin
          send_sample(OP_PRESSURE, 16'($urandom_range(45000, 15000)));
          n++;
        end
      end
    end
  endtask

  initial begin : stimulus
    bit realistic;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // With the reset calibration both divisors are zero: a pressure sample before
    // any temperature, then a temperature sample at the top of the raw range.
    gap_pct = 20;
    stall_pct = 20;
    send_sample(OP_PRESSURE, 16'h0000);
    send_sample(OP_TEMPERATURE, 16'hFFFF);
    drain();

    // Typical calibration: pressure still on a zero B5, the worked example, and
    // the ends of the raw range for both kinds.
    cal_write_all(TYPICAL_AC123, TYPICAL_AC456, TYPICAL_B12, TYPICAL_MCMD);
    send_sample(OP_PRESSURE, 16'd23843);
    send_sample(OP_TEMPERATURE, 16'd27898);
    send_sample(OP_PRESSURE, 16'd23843);
    send_sample(OP_TEMPERATURE, 16'h0000);
    send_sample(OP_TEMPERATURE, 16'hFFFF);
    send_sample(OP_PRESSURE, 16'h0000);
    send_sample(OP_PRESSURE, 16'hFFFF);
    send_sample(OP_TEMPERATURE, 16'd27898);
    send_sample(OP_PRESSURE, 16'd40000);
    drain();

    // AC5 = 32768 and AC6 = 0 make X1 equal to the raw reading, so MD = -1000 gives
    // a zero temperature divisor at 1000. The pressure word after it shows that B5
    // kept the value from the good temperature word before.
    cal_write(REG_CAL_AC456, {16'h7FE5, 16'h8000, 16'h0000});
    cal_write(REG_CAL_MCMD, {16'hDDF9, 16'hFC18});
    send_sample(OP_TEMPERATURE, 16'd2000);
    send_sample(OP_TEMPERATURE, 16'd1000);
    send_sample(OP_PRESSURE, 16'd23843);
    drain();

    // All calibration bits set, with garbage above each register's width.
    cal_write_all('1, '1, '1, '1);
    send_sample(OP_TEMPERATURE, 16'h0000);
    send_sample(OP_TEMPERATURE, 16'hFFFF);
    send_sample(OP_PRESSURE, 16'h0000);
    send_sample(OP_PRESSURE, 16'hFFFF);
    drain();

    // AC4 = 0 forces B4 to zero, so the pressure divisor is zero.
    cal_write_all(TYPICAL_AC123, {16'h0000, TYPICAL_AC456[31:0]}, TYPICAL_B12, TYPICAL_MCMD);
    send_sample(OP_PRESSURE, 16'd23843);
    drain();

    // Random phases, alternating plausible and fully random calibration. Halfway
    // through each phase the sender holds back until every result is in. The last
    // phase runs with neither idling nor stalls.
    for (int ph = 0; ph < 7; ph++) begin
      realistic = (ph % 2 == 0);
      gap_pct = (ph == 6) ? 0 : 20 * $urandom_range(2);
      stall_pct = (ph == 6) ? 0 : 20 * $urandom_range(2);
      if (realistic)
        cal_write_all({16'($urandom_range(9000, 200)), 16'(-$urandom_range(1500, 0)),
                       16'(-$urandom_range(15000, 13000))},
                      {16'($urandom_range(34000, 31000)), 16'($urandom_range(33000, 24000)),
                       16'($urandom_range(24000, 15000))},
                      {16'($urandom_range(7000, 5000)), 16'($urandom_range(60, 0))},
                      {16'(-$urandom_range(12000, 8000)), 16'($urandom_range(3000, 2000))});
      else
        cal_write_all({$urandom, $urandom}, {$urandom, $urandom},
                      {$urandom, $urandom}, {$urandom, $urandom});
      queue_samples(75, realistic);
      drain();
      queue_samples(75, realistic);
      drain();
    end

    // Watch a while longer for results that should not be there.
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
